// File: hdl/rfap_pkg.sv
// Shared types, widths and codes of the rotated framebuffer pixel unit.
`default_nettype none

package rfap_pkg;

    // field widths
    localparam int unsigned X_W      = 10;
    localparam int unsigned Y_W      = 10;
    localparam int unsigned H_W      = 11;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned COLOUR_W = 32;
    localparam int unsigned BYTE_W   = 8;

    // address arithmetic: x*h, plus the flipped row, times the stride
    localparam int unsigned PROD_W = X_W + H_W;
    localparam int unsigned BASE_W = PROD_W + 1;
    localparam int unsigned ADDR_W = BASE_W + 2;

    // the store is split into byte lanes, one per address modulo four
    localparam int unsigned BYTE_LANES = 4;
    localparam int unsigned LANE_W     = $clog2(BYTE_LANES);
    localparam logic [LANE_W-1:0] ALPHA_LANE = LANE_W'(BYTE_LANES - 1);

    localparam int unsigned STORE_BYTES_DEF = 524288;
    localparam int unsigned QUEUE_DEPTH     = 2;

    // pixel layout
    localparam int unsigned STRIDE_NARROW = 3;
    localparam int unsigned STRIDE_WIDE   = 4;
    localparam logic [BPP_W-1:0]  BPP_WIDE     = BPP_W'(STRIDE_WIDE);
    localparam int unsigned       ALPHA_LSB    = 24;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // request kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // register file
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_SIZE    = REG_IDX_W'(1);
    localparam logic [H_W-1:0]   H_RESET   = H_W'(240);
    localparam logic [BPP_W-1:0] BPP_RESET = BPP_W'(3);

    // classified request handed from the front end to the back end
    typedef struct packed {
        logic                action;
        logic                wide;
        logic                oor;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;
    } t_req;

    typedef enum logic {
        BK_IDLE,
        BK_DATA
    } t_back_state;

endpackage

`default_nettype wire

// File: hdl/rotated_framebuffer_alpha_pixel_unit.sv
// Top level of the rotated framebuffer pixel unit with alpha blend.
// The byte lanes are read, then written, so the back end takes a new request
// only once the previous one has been written back.
// The front end keeps accepting while the back end works; a two-entry queue sits between them.
// Reset (synchronous, active low) clears control and restores canvas_height 240, pixel_size 3.
// Framebuffer contents are not cleared by reset and are undefined until written.
`default_nettype none

module rotated_framebuffer_alpha_pixel_unit #(
    parameter int unsigned STORE_BYTES = rfap_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [rfap_pkg::X_W-1:0]      i_x,
    input  logic [rfap_pkg::Y_W-1:0]      i_y,
    input  logic [rfap_pkg::COLOUR_W-1:0] i_colour,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rfap_pkg::COLOUR_W-1:0] o_read_colour,
    output logic                          o_out_of_range,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfap_pkg::PADDR_W-1:0]  paddr,
    input  logic [rfap_pkg::DATA_W-1:0]   pwdata,
    output logic [rfap_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rfap_pkg::*;

    logic [H_W-1:0]       r_canvas_height;
    logic [BPP_W-1:0]     r_pixel_size;
    logic                 reg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic push;
    t_req push_req;
    logic queue_full;
    logic head_valid;
    t_req head;
    logic pop;

    // ------------------------------------------------------------------
    // Register port. No wait states; the register is picked by word
    // address, the byte offset bits are ignored.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_height <= H_RESET;
            r_pixel_size    <= BPP_RESET;
        end else if (reg_wr) begin
            unique case (reg_idx)
                REG_CANVAS_HEIGHT: r_canvas_height <= pwdata[H_W-1:0];
                REG_PIXEL_SIZE:    r_pixel_size    <= pwdata[BPP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CANVAS_HEIGHT: prdata = DATA_W'(r_canvas_height);
            REG_PIXEL_SIZE:    prdata = DATA_W'(r_pixel_size);
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: three-stage address pipeline. Works out
    // (h-1-y + x*h) * stride and flags rows past the canvas and pixels
    // running off the end of the store. Registers are read live; the user must
    // see they are only rewritten while the unit is idle; the block does not check.
    // ------------------------------------------------------------------
    rfap_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_x             (i_x),
        .i_y             (i_y),
        .i_colour        (i_colour),
        .i_canvas_height (r_canvas_height),
        .i_pixel_size    (r_pixel_size),
        .o_push          (push),
        .o_push_req      (push_req),
        .i_queue_full    (queue_full)
    );

    // Classified requests wait here so the front end can run ahead.
    rfap_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_req   (push_req),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // ------------------------------------------------------------------
    // Back end: four byte lanes (address mod 4), so a pixel of three or
    // four bytes is read in a single access whatever its alignment. Pop cycle
    // issues the read; data cycle blends, writes back and loads the
    // result register. Read-after-write to the same pixel is safe since
    // the next read is only issued after the write.
    // ------------------------------------------------------------------
    rfap_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_colour  (o_read_colour),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// File: hdl/rfap_front.sv
// Front end: accepts requests, works out the byte address and the range check.
`default_nettype none

module rfap_front #(
    parameter int unsigned STORE_BYTES = rfap_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [rfap_pkg::X_W-1:0]      i_x,
    input  logic [rfap_pkg::Y_W-1:0]      i_y,
    input  logic [rfap_pkg::COLOUR_W-1:0] i_colour,
    input  logic [rfap_pkg::H_W-1:0]      i_canvas_height,
    input  logic [rfap_pkg::BPP_W-1:0]    i_pixel_size,
    output logic                          o_push,
    output rfap_pkg::t_req                o_push_req,
    input  logic                          i_queue_full
);
    import rfap_pkg::*;

    localparam logic [ADDR_W-1:0] LIM_NARROW = ADDR_W'(STORE_BYTES - STRIDE_NARROW);
    localparam logic [ADDR_W-1:0] LIM_WIDE   = ADDR_W'(STORE_BYTES - STRIDE_WIDE);

    // stage 1: captured request
    logic                r_s1_valid;
    logic                r_s1_action;
    logic [X_W-1:0]      r_s1_x;
    logic [Y_W-1:0]      r_s1_y;
    logic [COLOUR_W-1:0] r_s1_colour;

    // stage 2: column product and flipped row
    logic                r_s2_valid;
    logic                r_s2_action;
    logic                r_s2_wide;
    logic                r_s2_oor;
    logic [PROD_W-1:0]   r_s2_prod;
    logic [H_W-1:0]      r_s2_row;
    logic [COLOUR_W-1:0] r_s2_colour;

    // stage 3: pixel index
    logic                r_s3_valid;
    logic                r_s3_action;
    logic                r_s3_wide;
    logic                r_s3_oor;
    logic [BASE_W-1:0]   r_s3_base;
    logic [COLOUR_W-1:0] r_s3_colour;

    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic [ADDR_W-1:0] addr;
    logic              addr_oor;

    assign s3_ready   = !r_s3_valid || !i_queue_full;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_action <= i_action;
            r_s1_x      <= i_x;
            r_s1_y      <= i_y;
            r_s1_colour <= i_colour;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_action <= r_s1_action;
            r_s2_wide   <= (i_pixel_size == BPP_WIDE);
            r_s2_oor    <= (H_W'(r_s1_y) >= i_canvas_height);
            r_s2_prod   <= PROD_W'(r_s1_x) * PROD_W'(i_canvas_height);
            r_s2_row    <= H_W'(i_canvas_height - H_W'(1) - H_W'(r_s1_y));
            r_s2_colour <= r_s1_colour;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_action <= r_s2_action;
            r_s3_wide   <= r_s2_wide;
            r_s3_oor    <= r_s2_oor;
            r_s3_base   <= BASE_W'(r_s2_prod) + BASE_W'(r_s2_row);
            r_s3_colour <= r_s2_colour;
        end
    end

    // stride 4 is a shift, stride 3 one add
    always_comb begin
        if (r_s3_wide) begin
            addr     = {r_s3_base, 2'b00};
            addr_oor = (addr > LIM_WIDE);
        end else begin
            addr     = ADDR_W'(r_s3_base) + ADDR_W'({r_s3_base, 1'b0});
            addr_oor = (addr > LIM_NARROW);
        end
    end

    assign o_push            = r_s3_valid && !i_queue_full;
    assign o_push_req.action = r_s3_action;
    assign o_push_req.wide   = r_s3_wide;
    assign o_push_req.oor    = r_s3_oor || addr_oor;
    assign o_push_req.addr   = addr;
    assign o_push_req.colour = r_s3_colour;

endmodule

`default_nettype wire

// File: hdl/rfap_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module rfap_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfap_pkg::t_req i_push_req,
    output logic           o_full,
    output logic           o_head_valid,
    output rfap_pkg::t_req o_head,
    input  logic           i_pop
);
    import rfap_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_req             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entry[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rfap_back.sv
// Back end: byte-lane framebuffer, read-then-write sequencer, blend and result register.
`default_nettype none

module rfap_back #(
    parameter int unsigned STORE_BYTES = rfap_pkg::STORE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  rfap_pkg::t_req                i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rfap_pkg::COLOUR_W-1:0] o_read_colour,
    output logic                          o_out_of_range
);
    import rfap_pkg::*;

    localparam int unsigned BANK_DEPTH = (STORE_BYTES + BYTE_LANES - 1) / BYTE_LANES;
    localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);
    localparam int unsigned WORD_W     = ADDR_W - LANE_W;

    t_back_state r_state;
    t_back_state n_state;
    t_req        r_req;

    logic                r_out_valid;
    logic [COLOUR_W-1:0] r_read_colour;
    logic                r_oor;

    logic pop;
    logic done;
    logic out_free;
    logic opaque;

    logic [BYTE_LANES-1:0] rd_en;
    logic [BYTE_LANES-1:0] wr_en;
    logic [BANK_AW-1:0]    rd_idx   [BYTE_LANES];
    logic [BANK_AW-1:0]    wr_idx   [BYTE_LANES];
    logic [BYTE_W-1:0]     wr_data  [BYTE_LANES];
    logic [BYTE_W-1:0]     bank_q   [BYTE_LANES];
    logic [BYTE_W-1:0]     pix      [BYTE_LANES];
    logic [BYTE_W-1:0]     new_byte [BYTE_LANES];
    logic [BYTE_W-1:0]     alpha;
    logic [COLOUR_W-1:0]   result;

    // word of bank b holding a pixel's byte: the next word for lanes below the start lane
    function automatic logic [BANK_AW-1:0] bank_index(input logic [ADDR_W-1:0] addr,
                                                      input logic [LANE_W-1:0] bank);
        logic [WORD_W-1:0] idx;
        idx = addr[ADDR_W-1:LANE_W] + ((bank < addr[LANE_W-1:0]) ? WORD_W'(1) : WORD_W'(0));
        return idx[BANK_AW-1:0];
    endfunction

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            BK_IDLE: n_state = i_head_valid ? BK_DATA : BK_IDLE;
            BK_DATA: n_state = out_free ? BK_IDLE : BK_DATA;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_state)
            BK_IDLE: begin
                pop  = i_head_valid;
                done = 1'b0;
            end
            BK_DATA: begin
                pop  = 1'b0;
                done = out_free;
            end
        endcase
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_req <= i_head;
        end
    end

    // lane addressing and write data
    always_comb begin
        logic [LANE_W-1:0] jr;
        logic [LANE_W-1:0] jw;
        for (int b = 0; b < BYTE_LANES; b++) begin
            jr        = LANE_W'(b) - i_head.addr[LANE_W-1:0];
            jw        = LANE_W'(b) - r_req.addr[LANE_W-1:0];
            rd_idx[b] = bank_index(i_head.addr, LANE_W'(b));
            wr_idx[b] = bank_index(r_req.addr, LANE_W'(b));
            rd_en[b]  = pop && !i_head.oor && ((jr != ALPHA_LANE) || i_head.wide);
            wr_en[b]  = done && (r_req.action == ACT_WRITE) && !r_req.oor &&
                        ((jw != ALPHA_LANE) || (r_req.wide && !opaque));
            wr_data[b] = new_byte[jw];
        end
    end

    // byte j of the pixel sits in lane (start + j)
    always_comb begin
        logic [LANE_W-1:0] lane;
        for (int j = 0; j < BYTE_LANES; j++) begin
            lane   = r_req.addr[LANE_W-1:0] + LANE_W'(j);
            pix[j] = bank_q[lane];
        end
    end

    assign alpha  = r_req.colour[ALPHA_LSB +: BYTE_W];
    assign opaque = (alpha == ALPHA_OPAQUE);

    // (src*a + dst*(255-a)) >> 8 per colour channel, src itself when opaque
    always_comb begin
        logic [BYTE_W-1:0]   src;
        logic [2*BYTE_W-1:0] sum;
        for (int j = 0; j < BYTE_LANES - 1; j++) begin
            src = r_req.colour[BYTE_W*j +: BYTE_W];
            sum = (2*BYTE_W)'(src) * (2*BYTE_W)'(alpha) +
                  (2*BYTE_W)'(pix[j]) * (2*BYTE_W)'(ALPHA_OPAQUE - alpha);
            new_byte[j] = opaque ? src : sum[2*BYTE_W-1:BYTE_W];
        end
        new_byte[ALPHA_LANE] = alpha;
    end

    for (genvar b = 0; b < BYTE_LANES; b++) begin : g_bank
        logic [BYTE_W-1:0] r_mem [BANK_DEPTH];
        logic [BYTE_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (wr_en[b]) begin
                r_mem[wr_idx[b]] <= wr_data[b];
            end
            if (rd_en[b]) begin
                r_q <= r_mem[rd_idx[b]];
            end
        end

        assign bank_q[b] = r_q;
    end

    // result register
    always_comb begin
        if (r_req.oor || (r_req.action == ACT_WRITE)) begin
            result = '0;
        end else begin
            result = {r_req.wide ? pix[ALPHA_LANE] : ALPHA_OPAQUE, pix[2], pix[1], pix[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_read_colour <= result;
            r_oor         <= r_req.oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_colour  = r_read_colour;
    assign o_out_of_range = r_oor;

    // a popped request always moves on to its data cycle
    a_pop_to_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state == BK_DATA))
        else $error("back end did not enter data cycle after pop");

    // store is only written for an in-range write request
    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en != '0) |-> (!r_req.oor && (r_req.action == ACT_WRITE)))
        else $error("store written for a refused or read request");

    // a three-byte pixel touches exactly three lanes
    a_narrow_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((wr_en != '0) && !r_req.wide) |-> ($countones(wr_en) == 3))
        else $error("three-byte write touched the wrong number of lanes");

    // a refused access carries no colour
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_oor) |-> (r_read_colour == '0))
        else $error("out-of-range result with non-zero colour");

endmodule

`default_nettype wire
